// ===== rtl/huffman_symbol_bit_packer_defines.svh =====
// Assertion macros shared by the Huffman bit packer RTL.
`ifndef HUFFMAN_SYMBOL_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_SYMBOL_BIT_PACKER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define HSBP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define HSBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hsbp_pkg.sv =====
// Package with types and constants of the Huffman bit packer.
package hsbp_pkg;

   // Command codes of an input transaction
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   localparam int WORD_BITS   = 32;
   localparam int CODE_BITS   = 31;
   localparam int LEN_BITS    = 5;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = 3;
   localparam int FIFO_CW     = 4;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   // Input transaction payload
   typedef struct packed {
      logic [1:0]            cmd;
      logic [7:0]            symbol;
      logic [CODE_BITS-1:0]  code_bits;
      logic [LEN_BITS-1:0]   code_length;
      logic [7:0]            data_byte;
   } req_payload_type;

   // Result transaction payload
   typedef struct packed {
      logic [WORD_BITS-1:0]  out_word;
      logic                  last;
   } rsp_payload_type;

   // One codebook entry: right-aligned code and its length
   typedef struct packed {
      logic [CODE_BITS-1:0]  code;
      logic [LEN_BITS-1:0]   len;
   } entry_type;

endpackage

// ===== rtl/huffman_symbol_bit_packer.sv =====
// Huffman bit packer top level. A load transaction writes one codebook entry,
// an encode transaction looks up the code of a byte (or of its low nibble and
// then its high nibble when four_bit_mode is set) and packs it MSB-first into
// a 32-bit word, and a flush transaction emits a partial word with zero low
// bits. After an item is accepted, the codebook RAM read happens at the
// accepting edge, the stage 2 registers then hold the joined up to two
// codes, and the barrel shift into the packing word and the queue write
// follow; the word can then leave the queue. One item can be accepted
// every cycle while req_stall is low; each item yields zero, one or two
// words, and the output side delivers one word per cycle while rsp_stall
// is low, so a run of items that each fill two words is held back by the
// output side. An eight-entry result queue parts the two sides; req_stall
// rises when the queue might not hold the words of all items in flight.
// The codebook has no reset and must be loaded before a symbol is encoded.
module huffman_symbol_bit_packer
   import hsbp_pkg::*;
#(
   parameter int SYMBOLS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

`include "huffman_symbol_bit_packer_defines.svh"

   localparam int AW = $clog2(SYMBOLS);

   // Mode register
   logic four_bit_mode_ff;

   // Codebook RAM and read ports
   entry_type book_mem [SYMBOLS];
   entry_type rd_a_ff, rd_b_ff;
   logic [AW-1:0] addr_a, addr_b;
   logic          req_accept;
   logic          sym_ok, byte_ok;
   logic [CODE_BITS-1:0] load_mask;

   // Stage 1: after RAM read
   logic s1_valid_ff, s1_encode_ff, s1_flush_ff, s1_nibble_ff, s1_ok_ff;

   // Stage 2: joined codes
   logic                 s2_valid_ff, s2_flush_ff;
   logic [2*CODE_BITS-1:0] s2_comb_ff;
   logic [5:0]           s2_len_ff;
   logic [2*CODE_BITS-1:0] s2_comb_in;
   logic [5:0]           s2_len_in;
   logic [LEN_BITS-1:0]  len_a, len_b;
   logic [CODE_BITS-1:0] code_a, code_b, la_a, la_b;

   // Packer state
   logic [WORD_BITS-1:0] pack_ff, pack_in;
   logic [4:0]           used_ff, used_in;
   logic [3*WORD_BITS-1:0] acc;
   logic [6:0]           total;

   // Result queue
   rsp_payload_type      fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic [1:0]           push_n;
   rsp_payload_type      word0, word1;
   logic                 rsp_pop;
   logic [FIFO_CW:0]     room_need;

   // Accept when the queue can take the words of every item in flight
   assign room_need = (FIFO_CW+1)'(count_ff) + (FIFO_CW+1)'({s1_valid_ff, 1'b0})
                    + (FIFO_CW+1)'({s2_valid_ff, 1'b0}) + (FIFO_CW+1)'(2);
   assign req_stall  = room_need > (FIFO_CW+1)'(FIFO_DEPTH);
   assign req_accept = req_valid && !req_stall;

   // Write the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         four_bit_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         four_bit_mode_ff <= csr_wr_data;
      end
   end

   // Pick lookup addresses and range checks
   always_comb begin
      sym_ok    = {1'b0, req_data.symbol} < 9'(SYMBOLS);
      byte_ok   = {1'b0, req_data.data_byte} < 9'(SYMBOLS);
      addr_a    = four_bit_mode_ff ? AW'(req_data.data_byte[3:0] & NIBBLE_MASK)
                                   : req_data.data_byte[AW-1:0];
      addr_b    = AW'(req_data.data_byte[7:4] & NIBBLE_MASK);
      load_mask = {CODE_BITS{1'b1}} >> (5'd31 - req_data.code_length);
   end

   // Write a loaded entry, read both lookups
   always_ff @(posedge clock) begin
      if (req_accept && req_data.cmd == CMD_LOAD && sym_ok) begin
         book_mem[req_data.symbol[AW-1:0]] <= '{code: req_data.code_bits & load_mask,
                                                len:  req_data.code_length};
      end
      rd_a_ff <= book_mem[addr_a];
      rd_b_ff <= book_mem[addr_b];
   end

   // Advance stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      s1_encode_ff <= req_data.cmd == CMD_ENCODE;
      s1_flush_ff  <= req_data.cmd == CMD_FLUSH;
      s1_nibble_ff <= four_bit_mode_ff;
      s1_ok_ff     <= four_bit_mode_ff || byte_ok;
   end

   // Join the two codes left-aligned into one field
   always_comb begin
      len_a  = '0;
      code_a = '0;
      len_b  = '0;
      code_b = '0;
      if (s1_encode_ff && s1_ok_ff) begin
         len_a  = rd_a_ff.len;
         code_a = rd_a_ff.code;
      end
      if (s1_encode_ff && s1_nibble_ff) begin
         len_b  = rd_b_ff.len;
         code_b = rd_b_ff.code;
      end
      la_a       = code_a << (5'd31 - len_a);
      la_b       = code_b << (5'd31 - len_b);
      s2_comb_in = {la_a, {CODE_BITS{1'b0}}} | ({la_b, {CODE_BITS{1'b0}}} >> len_a);
      s2_len_in  = 6'(len_a) + 6'(len_b);
   end

   // Advance stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_flush_ff <= s1_flush_ff;
      s2_comb_ff  <= s2_comb_in;
      s2_len_ff   <= s2_len_in;
   end

   // Merge the codes into the packing word and split off full words
   always_comb begin
      acc     = {pack_ff, {2*WORD_BITS{1'b0}}}
              | ({s2_comb_ff, {(3*WORD_BITS-2*CODE_BITS){1'b0}}} >> used_ff);
      total   = 7'(used_ff) + 7'(s2_len_ff);
      pack_in = pack_ff;
      used_in = used_ff;
      push_n  = 2'd0;
      word0   = '{out_word: acc[3*WORD_BITS-1:2*WORD_BITS], last: 1'b1};
      word1   = '{out_word: acc[2*WORD_BITS-1:WORD_BITS], last: 1'b1};
      if (s2_valid_ff) begin
         if (s2_flush_ff) begin
            if (used_ff != 5'd0) begin
               push_n = 2'd1;
            end
            pack_in = '0;
            used_in = '0;
         end else if (total >= 7'd64) begin
            push_n     = 2'd2;
            word0.last = 1'b0;
            pack_in    = acc[WORD_BITS-1:0];
            used_in    = 5'(total - 7'd64);
         end else if (total >= 7'd32) begin
            push_n  = 2'd1;
            pack_in = acc[2*WORD_BITS-1:WORD_BITS];
            used_in = 5'(total - 7'd32);
         end else begin
            pack_in = acc[3*WORD_BITS-1:2*WORD_BITS];
            used_in = 5'(total);
         end
      end
   end

   // Hold the packing word
   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff <= '0;
         used_ff <= '0;
      end else begin
         pack_ff <= pack_in;
         used_ff <= used_in;
      end
   end

   // Result queue
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign rsp_pop   = rsp_valid && !rsp_stall;
   assign count_in  = count_ff + FIFO_CW'(push_n) - FIFO_CW'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(rsp_pop);
         count_ff  <= count_in;
      end
   end

   // Write up to two words per cycle
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= word0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= word1;
      end
   end

   // Checks
   `HSBP_ASSERT_SAME(a_no_overflow, clock, reset, s2_valid_ff,
      (FIFO_CW+1)'(count_ff) + (FIFO_CW+1)'(push_n) <= (FIFO_CW+1)'(FIFO_DEPTH),
      "result queue overflow")
   `HSBP_ASSERT_NEXT(a_flush_clears, clock, reset, s2_valid_ff && s2_flush_ff,
      used_ff == 5'd0 && pack_ff == '0, "flush left bits in the packing word")
   `HSBP_ASSERT_SAME(a_ptr_count, clock, reset, 1'b1,
      wr_ptr_ff == rd_ptr_ff + count_ff[FIFO_AW-1:0], "queue pointers out of step")

endmodule
